@@ hw/rtl/gip_pkg.sv @@
// Shared widths, register indexes, types and helpers for the ground-to-image
// projection block. No dependencies.
`default_nettype none
package gip_pkg;

    localparam int COEF_W   = 20;
    localparam int GND_W    = 32;
    localparam int DIFF_W   = 33;
    localparam int PROD_W   = 53;
    localparam int SUM_W    = 55;
    localparam int MAG_W    = 54;
    localparam int FOC_W    = 24;
    localparam int SPLIT_W  = 27;
    localparam int PART_W   = FOC_W + SPLIT_W;
    localparam int NUM_W    = FOC_W + MAG_W;
    localparam int QUOT_W   = 26;
    localparam int SQ_W     = QUOT_W + 2;
    localparam int FULL_W   = 30;
    localparam int OUT_W    = 24;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROT0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOFF   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMSIZE = 3'd7;

    localparam logic signed [FULL_W-1:0] OUT_MAX = FULL_W'(8388607);
    localparam logic signed [FULL_W-1:0] OUT_MIN = -FULL_W'(8388608);

    typedef struct packed {
        logic zero;
        logic neg;
    } div_tag_t;

    function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_DATA_W-1:0] row,
                                                      input int idx);
        coef = row[idx*COEF_W +: COEF_W];
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [FULL_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > OUT_MAX)
        begin
            r = OUT_MAX[OUT_W-1:0];
        end
        else if (v < OUT_MIN)
        begin
            r = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        sat_out = r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ground_to_image_projection_top.sv @@
// Ground-to-image projection top level: configuration registers, product and
// sum stages, two pipelined dividers, output stage with skid buffer.
// Depends on gip_pkg and gip_div_pipe.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   input    | in_valid / in_stall   | ground_x_mm, ground_y_mm
//   output   | out_valid / out_stall | image_row, image_col, in_bounds
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One point enters per cycle while in_stall is low; the pipeline is the 27 stages of
// each divider plus eight arithmetic and output stages.
// Reset clears all valid bits and the configuration registers.
// A skid register behind the output register absorbs one transfer; in_stall is
// the registered skid occupancy, and the whole pipeline holds while it is full.
`default_nettype none
module ground_to_image_projection_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [gip_pkg::GND_W-1:0]      ground_x_mm,
    input  wire logic signed [gip_pkg::GND_W-1:0]      ground_y_mm,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [gip_pkg::OUT_W-1:0]           image_row,
    output logic signed [gip_pkg::OUT_W-1:0]           image_col,
    output logic                                       in_bounds,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [gip_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [gip_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import gip_pkg::*;

    logic [CFG_DATA_W-1:0]     rot_reg [0:2];
    logic signed [GND_W-1:0]   cam_x_reg;
    logic signed [GND_W-1:0]   cam_y_reg;
    logic signed [GND_W-1:0]   voff_reg;
    logic [FOC_W-1:0]          focal_reg;
    logic [31:0]               imsize_reg;

    logic adv;

    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vf_reg;
    logic signed [DIFF_W-1:0]  dvec_reg [0:1];
    logic signed [DIFF_W-1:0]  dvec    [0:2];
    logic signed [PROD_W-1:0]  prod_reg [0:2][0:2];
    logic signed [SUM_W-1:0]   c_reg [0:2];
    logic [MAG_W-1:0]          mag_reg [0:2];
    logic                      neg0_reg, neg1_reg, zero4_reg;
    logic [PART_W-1:0]         plo_reg [0:1];
    logic [PART_W-1:0]         phi_reg [0:1];
    logic [MAG_W-1:0]          den5_reg;
    div_tag_t                  tag5_reg [0:1];
    logic [NUM_W-1:0]          num_reg [0:1];
    logic [MAG_W-1:0]          den6_reg;
    div_tag_t                  tag6_reg [0:1];

    logic                      dv0, dv1;
    logic [QUOT_W-1:0]         dq0, dq1;
    logic                      dovf0, dovf1;
    div_tag_t                  dtag0, dtag1;

    logic signed [SQ_W-1:0]    sq0_reg, sq1_reg;
    logic                      zerof_reg;
    logic signed [SQ_W-1:0]    sq0_next, sq1_next;

    logic [OUT_W-1:0]          row_next, col_next;
    logic                      inb_next;
    logic                      push;

    logic                      out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0]          row_reg, col_reg, skid_row_reg, skid_col_reg;
    logic                      inb_reg, skid_inb_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= '0;
            rot_reg[1] <= '0;
            rot_reg[2] <= '0;
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            voff_reg   <= '0;
            focal_reg  <= '0;
            imsize_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROT0:   rot_reg[0] <= cfg_data;
                REG_ROT1:   rot_reg[1] <= cfg_data;
                REG_ROT2:   rot_reg[2] <= cfg_data;
                REG_CAM_X:  cam_x_reg  <= cfg_data[GND_W-1:0];
                REG_CAM_Y:  cam_y_reg  <= cfg_data[GND_W-1:0];
                REG_VOFF:   voff_reg   <= cfg_data[GND_W-1:0];
                REG_FOCAL:  focal_reg  <= cfg_data[FOC_W-1:0];
                REG_IMSIZE: imsize_reg <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            vf_reg <= dv0;
        end
    end

    assign dvec[0] = dvec_reg[0];
    assign dvec[1] = dvec_reg[1];
    assign dvec[2] = DIFF_W'(voff_reg);

    always_comb
    begin
        logic signed [SQ_W-1:0] m0;
        logic signed [SQ_W-1:0] m1;
        m0 = dovf0 ? SQ_W'(1) <<< QUOT_W : SQ_W'({1'b0, dq0});
        m1 = dovf1 ? SQ_W'(1) <<< QUOT_W : SQ_W'({1'b0, dq1});
        sq0_next = dtag0.neg ? -m0 : m0;
        sq1_next = dtag1.neg ? -m1 : m1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvec_reg[0] <= DIFF_W'(ground_x_mm) - DIFF_W'(cam_x_reg);
            dvec_reg[1] <= DIFF_W'(ground_y_mm) - DIFF_W'(cam_y_reg);
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[r][j] <= PROD_W'(coef(rot_reg[r], j)) * PROD_W'(dvec[j]);
                end
                c_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                            + SUM_W'(prod_reg[r][2]);
                mag_reg[r] <= c_reg[r][SUM_W-1] ? MAG_W'(-c_reg[r]) : MAG_W'(c_reg[r]);
            end
            neg0_reg  <= c_reg[0][SUM_W-1] ^ c_reg[2][SUM_W-1];
            neg1_reg  <= c_reg[1][SUM_W-1] ^ c_reg[2][SUM_W-1];
            zero4_reg <= c_reg[2] == '0;
            for (int l = 0; l < 2; l++)
            begin
                plo_reg[l] <= PART_W'(focal_reg) * PART_W'(mag_reg[l][SPLIT_W-1:0]);
                phi_reg[l] <= PART_W'(focal_reg) * PART_W'(mag_reg[l][MAG_W-1:SPLIT_W]);
                num_reg[l] <= NUM_W'(plo_reg[l]) + {phi_reg[l], SPLIT_W'(0)};
                tag6_reg[l] <= tag5_reg[l];
            end
            den5_reg    <= mag_reg[2];
            tag5_reg[0] <= '{zero: zero4_reg, neg: neg0_reg};
            tag5_reg[1] <= '{zero: zero4_reg, neg: neg1_reg};
            den6_reg    <= den5_reg;
            sq0_reg     <= sq0_next;
            sq1_reg     <= sq1_next;
            zerof_reg   <= dtag0.zero;
        end
    end

    gip_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (MAG_W),
        .QUOT_W (QUOT_W)
    ) u_div0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v6_reg),
        .num       (num_reg[0]),
        .den       (den6_reg),
        .tag_in    (tag6_reg[0]),
        .out_valid (dv0),
        .quot      (dq0),
        .ovf       (dovf0),
        .tag_out   (dtag0)
    );

    gip_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (MAG_W),
        .QUOT_W (QUOT_W)
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v6_reg),
        .num       (num_reg[1]),
        .den       (den6_reg),
        .tag_in    (tag6_reg[1]),
        .out_valid (dv1),
        .quot      (dq1),
        .ovf       (dovf1),
        .tag_out   (dtag1)
    );

    always_comb
    begin
        logic signed [FULL_W-1:0] row_full;
        logic signed [FULL_W-1:0] col_full;
        logic signed [FULL_W-1:0] row_lim;
        logic signed [FULL_W-1:0] col_lim;
        row_full = $signed(FULL_W'({imsize_reg[31:17], 8'h00})) - FULL_W'(sq1_reg);
        col_full = $signed(FULL_W'({imsize_reg[15:1], 8'h00})) + FULL_W'(sq0_reg);
        row_lim  = $signed(FULL_W'({imsize_reg[31:16], 8'h00}));
        col_lim  = $signed(FULL_W'({imsize_reg[15:0], 8'h00}));
        if (zerof_reg)
        begin
            row_next = '0;
            col_next = '0;
            inb_next = 1'b0;
        end
        else
        begin
            row_next = sat_out(row_full);
            col_next = sat_out(col_full);
            inb_next = (row_full >= 0) && (row_full <= row_lim)
                       && (col_full >= 0) && (col_full <= col_lim);
        end
    end

    assign push = adv && vf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                row_reg <= skid_row_reg;
                col_reg <= skid_col_reg;
                inb_reg <= skid_inb_reg;
            end
            else
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                inb_reg <= inb_next;
            end
        end
        else if (push)
        begin
            skid_row_reg <= row_next;
            skid_col_reg <= col_next;
            skid_inb_reg <= inb_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign image_row = row_reg;
    assign image_col = col_reg;
    assign in_bounds = inb_reg;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dv0 == dv1)
        else $error("Divider lanes lost alignment.");

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a transfer while the output is empty.");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("Skid register dropped a stalled transfer.");

    a_inbounds_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_bounds) |-> (!image_row[OUT_W-1] && !image_col[OUT_W-1]))
        else $error("In-bounds point has a negative coordinate.");

endmodule
`default_nettype wire

@@ hw/rtl/gip_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on gip_pkg for default widths and the tag type.
`default_nettype none
module gip_div_pipe #(
    parameter int NUM_W  = gip_pkg::NUM_W,
    parameter int DEN_W  = gip_pkg::MAG_W,
    parameter int QUOT_W = gip_pkg::QUOT_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  gip_pkg::div_tag_t      tag_in,
    output logic                   out_valid,
    output logic [QUOT_W-1:0]      quot,
    output logic                   ovf,
    output gip_pkg::div_tag_t      tag_out
);
    import gip_pkg::*;

    localparam int HI_W  = NUM_W - QUOT_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic              valid_reg [0:QUOT_W];
    logic [DEN_W-1:0]  rem_reg   [0:QUOT_W];
    logic [DEN_W-1:0]  rem_next  [0:QUOT_W];
    logic [QUOT_W-1:0] lq_reg    [0:QUOT_W];
    logic [QUOT_W-1:0] lq_next   [0:QUOT_W];
    logic [DEN_W-1:0]  den_reg   [0:QUOT_W];
    logic              ovf_reg   [0:QUOT_W];
    logic              ovf_next;
    div_tag_t          tag_reg   [0:QUOT_W];

    always_comb
    begin
        logic [HI_W-1:0]  hi;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        hi = num[NUM_W-1:QUOT_W];
        ovf_next = CMP_W'(hi) >= CMP_W'(den);
        rem_next[0] = ovf_next ? '0 : DEN_W'(hi);
        lq_next[0] = num[QUOT_W-1:0];
        for (int k = 1; k <= QUOT_W; k++)
        begin
            trial = {rem_reg[k-1], lq_reg[k-1][QUOT_W-1]};
            diff = trial - {1'b0, den_reg[k-1]};
            ge = trial >= {1'b0, den_reg[k-1]};
            rem_next[k] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            lq_next[k] = {lq_reg[k-1][QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QUOT_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= QUOT_W; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rem_next[0];
            lq_reg[0]  <= lq_next[0];
            den_reg[0] <= den;
            ovf_reg[0] <= ovf_next;
            tag_reg[0] <= tag_in;
            for (int k = 1; k <= QUOT_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lq_reg[k]  <= lq_next[k];
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W];
    assign quot      = lq_reg[QUOT_W];
    assign ovf       = ovf_reg[QUOT_W];
    assign tag_out   = tag_reg[QUOT_W];

endmodule
`default_nettype wire

@@ tb/sv/ground_to_image_projection_top_tb.sv @@
// Self-checking testbench for ground_to_image_projection_top: directed and random ground
// points under several camera setups, checked against an in-bench projection predictor.
// Depends on gip_pkg and the block's RTL.
module ground_to_image_projection_top_tb;
    import gip_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] row;
        logic signed [OUT_W-1:0] col;
        logic                    inb;
    } pixel_t;

    typedef enum int {SETUP_RESET, SETUP_UNIT, SETUP_REALISTIC, SETUP_RANDOM, SETUP_EXTREME}
        setup_t;

    typedef struct {
        int     x;
        int     y;
        setup_t setup;
        bit     typed;
        pixel_t want;
    } point_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [GND_W-1:0]     ground_x_mm;
    logic signed [GND_W-1:0]     ground_y_mm;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [OUT_W-1:0]     image_row;
    logic signed [OUT_W-1:0]     image_col;
    logic                        in_bounds;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    logic [CFG_DATA_W-1:0]       rot [3];
    int                          cam_x;
    int                          cam_y;
    int                          voff;
    logic [FOC_W-1:0]            focal;
    logic [31:0]                 img_size;

    pixel_t                      pending_pixels[$];
    int                          mismatches;
    int                          points_sent;
    int                          pixels_seen;
    int                          send_idle_pct;
    int                          stall_pct;
    setup_t                      cur_setup;

    ground_to_image_projection_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .ground_x_mm(ground_x_mm),
        .ground_y_mm(ground_y_mm),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .image_row(image_row),
        .image_col(image_col),
        .in_bounds(in_bounds),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CFG_DATA_W-1:0] pack_row(input int a, input int b, input int c);
        logic [19:0] pa;
        logic [19:0] pb;
        logic [19:0] pc;
        pa = a[19:0];
        pb = b[19:0];
        pc = c[19:0];
        return {pc, pb, pa};
    endfunction

    function automatic longint rotate_dot(input logic [CFG_DATA_W-1:0] r, input longint dx,
                                          input longint dy, input longint dz);
        longint a;
        longint b;
        longint c;
        a = longint'($signed(r[19:0]));
        b = longint'($signed(r[39:20]));
        c = longint'($signed(r[59:40]));
        return a * dx + b * dy + c * dz;
    endfunction

    function automatic longint focal_quotient(input longint num, input longint den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] p;
        bit           neg;
        longint       q;
        neg = (num < 0) != (den < 0);
        n = 128'(num < 0 ? -num : num);
        d = 128'(den < 0 ? -den : den);
        p = (n * 128'(focal)) / d;
        if (p > (128'd1 << 40))
        begin
            p = 128'd1 << 40;
        end
        q = longint'(p[63:0]);
        return neg ? -q : q;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_coord(input longint v);
        if (v > 8388607)
        begin
            return 24'sd8388607;
        end
        if (v < -8388608)
        begin
            return -24'sd8388608;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic pixel_t project_point(input int x, input int y);
        longint dx;
        longint dy;
        longint dz;
        longint c0;
        longint c1;
        longint c2;
        longint rows;
        longint cols;
        longint rf;
        longint cf;
        pixel_t p;
        dx = longint'(x) - longint'(cam_x);
        dy = longint'(y) - longint'(cam_y);
        dz = longint'(voff);
        c0 = rotate_dot(rot[0], dx, dy, dz);
        c1 = rotate_dot(rot[1], dx, dy, dz);
        c2 = rotate_dot(rot[2], dx, dy, dz);
        rows = longint'(img_size[31:16]);
        cols = longint'(img_size[15:0]);
        if (c2 == 0)
        begin
            p.row = '0;
            p.col = '0;
            p.inb = 1'b0;
            return p;
        end
        rf = (rows >> 1) * 256 - focal_quotient(c1, c2);
        cf = (cols >> 1) * 256 + focal_quotient(c0, c2);
        p.row = clamp_coord(rf);
        p.col = clamp_coord(cf);
        p.inb = (rf >= 0 && rf <= rows * 256 && cf >= 0 && cf <= cols * 256);
        return p;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(2))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return 0;
        endcase
    endfunction

    function automatic int pick_coef_extreme();
        case ($urandom_range(3))
            0: return -524288;
            1: return 524287;
            2: return 262144;
            default: return 0;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_setup(input setup_t s);
        logic [CFG_DATA_W-1:0] junk;
        cur_setup = s;
        case (s)
            SETUP_UNIT:
            begin
                rot[0] = pack_row(262144, 0, 0);
                rot[1] = pack_row(0, 262144, 0);
                rot[2] = pack_row(0, 0, 262144);
                cam_x = 0;
                cam_y = 0;
                voff = 1;
                focal = 24'd256;
                img_size = {16'd100, 16'd100};
            end
            SETUP_REALISTIC:
            begin
                rot[0] = pack_row(262144 + $urandom_range(8000) - 4000,
                                  $urandom_range(8000) - 4000, $urandom_range(8000) - 4000);
                rot[1] = pack_row($urandom_range(8000) - 4000,
                                  262144 + $urandom_range(8000) - 4000,
                                  $urandom_range(8000) - 4000);
                rot[2] = pack_row($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                                  -262144 + $urandom_range(8000) - 4000);
                cam_x = int'($urandom_range(32'h7fff_ffff)) - 32'sh4000_0000;
                cam_y = int'($urandom_range(32'h7fff_ffff)) - 32'sh4000_0000;
                voff = -int'($urandom_range(5000, 500));
                focal = 24'($urandom_range(3000, 100)) << 8;
                img_size = {16'($urandom_range(4000, 200)), 16'($urandom_range(4000, 200))};
            end
            SETUP_RANDOM:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rot[k] = CFG_DATA_W'({$urandom, $urandom});
                end
                cam_x = $urandom;
                cam_y = $urandom;
                voff = $urandom;
                focal = FOC_W'($urandom);
                img_size = $urandom;
            end
            SETUP_EXTREME:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rot[k] = pack_row(pick_coef_extreme(), pick_coef_extreme(),
                                      pick_coef_extreme());
                end
                cam_x = pick_extreme();
                cam_y = pick_extreme();
                voff = pick_extreme();
                focal = $urandom_range(1) ? 24'hff_ffff : 24'h00_0000;
                img_size = $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
            end
            default:
            begin
            end
        endcase
        if (s == SETUP_RESET)
        begin
            return;
        end
        junk = CFG_DATA_W'({$urandom, $urandom});
        write_reg(REG_ROT0, rot[0]);
        write_reg(REG_ROT1, rot[1]);
        write_reg(REG_ROT2, rot[2]);
        write_reg(REG_CAM_X, {junk[59:32], cam_x});
        write_reg(REG_CAM_Y, {junk[27:0], cam_y});
        write_reg(REG_VOFF, {junk[59:32], voff});
        write_reg(REG_FOCAL, {junk[35:0], focal});
        write_reg(REG_IMSIZE, {junk[27:0], img_size});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_point(input int x, input int y, input bit typed, input pixel_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ground_x_mm <= x;
        ground_y_mm <= y;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_pixels.insert(pending_pixels.size(), typed ? want : project_point(x, y));
        points_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                pixels_seen++;
                if (pending_pixels.size() == 0)
                begin
                    $error("Unexpected output transfer: row %0d col %0d in_bounds %0b",
                           image_row, image_col, in_bounds);
                    mismatches++;
                end
                else
                begin
                    pixel_t w;
                    w = pending_pixels.pop_front();
                    if (image_row !== w.row)
                    begin
                        $error("image_row: expected %0d, got %0d", w.row, image_row);
                        mismatches++;
                    end
                    if (image_col !== w.col)
                    begin
                        $error("image_col: expected %0d, got %0d", w.col, image_col);
                        mismatches++;
                    end
                    if (in_bounds !== w.inb)
                    begin
                        $error("in_bounds: expected %0b, got %0b", w.inb, in_bounds);
                        mismatches++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        point_row_t table_rows[$];
        point_row_t e;
        pixel_t     w;
        int         x;
        int         y;
        int         span;
        setup_t     s;

        rst_n = 1'b0;
        in_valid = 1'b0;
        ground_x_mm = '0;
        ground_y_mm = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        points_sent = 0;
        pixels_seen = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        for (int k = 0; k < 3; k++)
        begin
            rot[k] = '0;
        end
        cam_x = 0;
        cam_y = 0;
        voff = 0;
        focal = '0;
        img_size = '0;

        // After reset the denominator is zero, so every point maps to zero, out of bounds.
        w = '{row: 24'sd0, col: 24'sd0, inb: 1'b0};
        e = '{0, 0, SETUP_RESET, 1, w};
        table_rows.insert(table_rows.size(), e);
        e = '{32'sh7fff_ffff, 32'sh8000_0000, SETUP_RESET, 1, w};
        table_rows.insert(table_rows.size(), e);
        e = '{32'sh8000_0000, 32'sh7fff_ffff, SETUP_RESET, 1, w};
        table_rows.insert(table_rows.size(), e);
        e = '{-1, -1, SETUP_RESET, 1, w};
        table_rows.insert(table_rows.size(), e);
        // Unit rotation, unit focal: one millimetre is one pixel, 100 by 100 image.
        e = '{0, 0, SETUP_UNIT, 1, '{24'sd12800, 24'sd12800, 1'b1}};
        table_rows.insert(table_rows.size(), e);
        e = '{50, -50, SETUP_UNIT, 1, '{24'sd25600, 24'sd25600, 1'b1}};
        table_rows.insert(table_rows.size(), e);
        e = '{-50, 50, SETUP_UNIT, 1, '{24'sd0, 24'sd0, 1'b1}};
        table_rows.insert(table_rows.size(), e);
        e = '{51, 0, SETUP_UNIT, 1, '{24'sd12800, 24'sd25856, 1'b0}};
        table_rows.insert(table_rows.size(), e);
        e = '{0, 51, SETUP_UNIT, 1, '{-24'sd256, 24'sd12800, 1'b0}};
        table_rows.insert(table_rows.size(), e);
        e = '{-51, 0, SETUP_UNIT, 1, '{24'sd12800, -24'sd256, 1'b0}};
        table_rows.insert(table_rows.size(), e);
        e = '{32'sh7fff_ffff, 0, SETUP_UNIT, 1, '{24'sd12800, 24'sd8388607, 1'b0}};
        table_rows.insert(table_rows.size(), e);
        e = '{0, 32'sh7fff_ffff, SETUP_UNIT, 1, '{-24'sd8388608, 24'sd12800, 1'b0}};
        table_rows.insert(table_rows.size(), e);
        e = '{32'sh8000_0000, 32'sh8000_0000, SETUP_UNIT, 1,
              '{24'sd8388607, -24'sd8388608, 1'b0}};
        table_rows.insert(table_rows.size(), e);
        e = '{17, -33, SETUP_UNIT, 0, w};
        table_rows.insert(table_rows.size(), e);
        e = '{0, 0, SETUP_EXTREME, 0, w};
        table_rows.insert(table_rows.size(), e);
        e = '{32'sh7fff_ffff, 32'sh7fff_ffff, SETUP_EXTREME, 0, w};
        table_rows.insert(table_rows.size(), e);
        e = '{32'sh8000_0000, 32'sh8000_0000, SETUP_EXTREME, 0, w};
        table_rows.insert(table_rows.size(), e);
        e = '{123, -456, SETUP_RANDOM, 0, w};
        table_rows.insert(table_rows.size(), e);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_setup = SETUP_RESET;
        foreach (table_rows[i])
        begin
            e = table_rows[i];
            if (e.setup != cur_setup)
            begin
                drain();
                load_setup(e.setup);
            end
            send_point(e.x, e.y, e.typed, e.want);
        end

        for (int p = 0; p < 12; p++)
        begin
            drain();
            case (p % 4)
                0: s = SETUP_REALISTIC;
                1: s = SETUP_RANDOM;
                2: s = SETUP_REALISTIC;
                default: s = SETUP_EXTREME;
            endcase
            load_setup(s);
            case ((p + p / 4) % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 67;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct = 27;
                    stall_pct = 27;
                end
            endcase
            span = $urandom_range(1) ? 2000 : 20000;
            for (int n = 0; n < 92; n++)
            begin
                if (s == SETUP_REALISTIC && $urandom_range(7) != 0)
                begin
                    x = cam_x + int'($urandom_range(2 * span)) - span;
                    y = cam_y + int'($urandom_range(2 * span)) - span;
                end
                else
                begin
                    x = $urandom;
                    y = $urandom;
                end
                send_point(x, y, 0, w);
            end
        end

        send_idle_pct = 0;
        drain();
        stall_pct = 0;
        $display("Projected %0d ground points, %0d results checked, over 16 camera setups",
                 points_sent, pixels_seen);
        $display("including reset, unit, realistic, random and extreme register settings.");
        if (mismatches == 0 && pending_pixels.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
